@@ hdl/bse_pkg.sv @@
// ----------------------------------------------------------------------------
// bse_pkg
// shared types, character constants and helpers for the byte string escaper
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 3;

  // escape scheme held in the mode register
  typedef enum logic [1:0] {
    MODE_JSON = 2'd0,
    MODE_C    = 2'd1,
    MODE_TSV  = 2'd2,
    MODE_MD   = 2'd3
  } mode_t;

  // shape of the output run for one input byte
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,   // byte itself
    KIND_PAIR = 2'd1,   // backslash + one character
    KIND_UHEX = 2'd2,   // backslash u 0 0 hex hex (lower case)
    KIND_XHEX = 2'd3    // backslash x hex hex (upper case)
  } esc_kind_t;

  // queue entry between classifier and sequencer
  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic [BYTE_W-1:0] code;
    esc_kind_t         kind;
  } esc_entry_t;

  // queue head as seen by the sequencer
  typedef struct packed {
    logic       valid;
    esc_entry_t entry;
  } q_head_t;

  // sequencer status
  typedef struct packed {
    logic mid_run;
  } back_stat_t;

  localparam logic [1:0] ADDR_MODE = 2'd0;

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_PIPE   = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LC_N   = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LC_R   = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LC_T   = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LC_U   = 8'h75;
  localparam logic [BYTE_W-1:0] CH_LC_X   = 8'h78;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;

  localparam logic [IDX_W-1:0] LAST_PASS = 3'd0;
  localparam logic [IDX_W-1:0] LAST_PAIR = 3'd1;
  localparam logic [IDX_W-1:0] LAST_UHEX = 3'd5;
  localparam logic [IDX_W-1:0] LAST_XHEX = 3'd3;

  // name letter for newline, cr, tab; zero when the byte has none
  function automatic logic [BYTE_W-1:0] named_ctrl(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = '0;
    if (b == CH_LF)  r = CH_LC_N;
    if (b == CH_CR)  r = CH_LC_R;
    if (b == CH_TAB) r = CH_LC_T;
    return r;
  endfunction

  // ascii hex digit for one nibble
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib, input logic upper);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'b0, nib};
    end else if (upper) begin
      r = CH_UC_A + {4'b0, nib} - 8'd10;
    end else begin
      r = CH_LC_A + {4'b0, nib} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] last_idx(input esc_kind_t k);
    logic [IDX_W-1:0] r;
    unique case (k)
      KIND_PASS: r = LAST_PASS;
      KIND_PAIR: r = LAST_PAIR;
      KIND_UHEX: r = LAST_UHEX;
      KIND_XHEX: r = LAST_XHEX;
      default:   r = LAST_PASS;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/bse_in_if.sv @@
// ----------------------------------------------------------------------------
// bse_in_if
// raw byte channel into the escaper
// ----------------------------------------------------------------------------
interface bse_in_if
  import bse_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ hdl/bse_out_if.sv @@
// ----------------------------------------------------------------------------
// bse_out_if
// escaped byte channel out of the escaper
// ----------------------------------------------------------------------------
interface bse_out_if
  import bse_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ hdl/bse_front.sv @@
// ----------------------------------------------------------------------------
// bse_front
// accepts raw bytes and classifies each into an escape run descriptor
// ----------------------------------------------------------------------------
module bse_front
  import bse_pkg::*;
(
  bse_in_if.sink     in_ch,
  input  mode_t      mode,
  input  logic       q_full,
  output logic       push,
  output esc_entry_t push_entry
);

  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] name;

  assign b    = in_ch.in_byte;
  assign name = named_ctrl(b);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_entry.raw  = b;
    push_entry.code = b;
    push_entry.kind = KIND_PASS;
    unique case (mode)
      MODE_JSON: begin
        if (b == CH_QUOTE || b == CH_BSLASH) begin
          push_entry.kind = KIND_PAIR;
        end else if (name != '0) begin
          push_entry.kind = KIND_PAIR;
          push_entry.code = name;
        end else if (b < CTRL_LIMIT) begin
          push_entry.kind = KIND_UHEX;
          push_entry.code = CH_LC_U;
        end
      end
      MODE_C: begin
        if (b == CH_BSLASH) begin
          push_entry.kind = KIND_PAIR;
        end else if (name != '0) begin
          push_entry.kind = KIND_PAIR;
          push_entry.code = name;
        end else if (b < CTRL_LIMIT || b == CH_DEL) begin
          push_entry.kind = KIND_XHEX;
          push_entry.code = CH_LC_X;
        end
      end
      MODE_TSV: begin
        if (b == CH_BSLASH) begin
          push_entry.kind = KIND_PAIR;
        end else if (name != '0) begin
          push_entry.kind = KIND_PAIR;
          push_entry.code = name;
        end
      end
      MODE_MD: begin
        if (b == CH_BSLASH || b == CH_PIPE) begin
          push_entry.kind = KIND_PAIR;
        end
      end
      default: begin
        push_entry.kind = KIND_PASS;
      end
    endcase
  end

endmodule

@@ hdl/bse_queue.sv @@
// ----------------------------------------------------------------------------
// bse_queue
// short descriptor queue between classifier and sequencer
// ----------------------------------------------------------------------------
module bse_queue
  import bse_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  esc_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output q_head_t    head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  esc_entry_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  assign full       = (count == CNT_FULL);
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 1'b1;
    if (pop && !push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

@@ hdl/bse_back.sv @@
// ----------------------------------------------------------------------------
// bse_back
// expands queued descriptors into escaped bytes, one per cycle while out_ch.ready is high
// ----------------------------------------------------------------------------
module bse_back
  import bse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_head_t    head,
  output logic       pop,
  output back_stat_t stat,
  bse_out_if.source  out_ch
);

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [BYTE_W-1:0] sel_byte;
  logic              is_last;
  logic              load;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  esc_entry_t        e;

  assign e        = head.entry;
  assign is_last  = (idx == last_idx(e.kind));
  assign load     = head.valid && (!out_valid || out_ch.ready);
  assign pop      = load && is_last;
  assign idx_next = is_last ? '0 : idx + 1'b1;

  assign stat.mid_run = (idx != '0);

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = out_last;

  always_comb begin
    sel_byte = CH_BSLASH;
    unique case (idx)
      3'd0: sel_byte = (e.kind == KIND_PASS) ? e.raw : CH_BSLASH;
      3'd1: sel_byte = e.code;
      3'd2: sel_byte = (e.kind == KIND_XHEX) ? hex_digit(e.raw[7:4], 1'b1) : CH_ZERO;
      3'd3: sel_byte = (e.kind == KIND_XHEX) ? hex_digit(e.raw[3:0], 1'b1) : CH_ZERO;
      3'd4: sel_byte = hex_digit(e.raw[7:4], 1'b0);
      3'd5: sel_byte = hex_digit(e.raw[3:0], 1'b0);
      default: sel_byte = CH_BSLASH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= idx_next;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      out_last <= is_last;
    end
  end

endmodule

@@ hdl/byte_string_escaper.sv @@
// ----------------------------------------------------------------------------
// byte_string_escaper
// per-byte string escaper for json, c, tsv and markdown text
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one raw byte per transaction (valid/ready). out_ch carries
//   the escaped run, one byte per transaction, with last set on the final
//   byte of each run. a run is 1, 2, 4 or 6 bytes long.
//   the mode register (apb, byte address 0) picks the scheme: 0 json, 1 c,
//   2 tsv, 3 markdown. write it only while no run is in flight.
// throughput:
//   an accepted byte enters the descriptor queue; its first output byte
//   is registered once it heads the queue and the output register is
//   free. the output side moves one byte per cycle while descriptors are
//   queued and out_ch.ready is high. the descriptor queue (QUEUE_DEPTH
//   entries) keeps input flowing at one byte per cycle while it has room.
// reset:
//   rst clears the queue, the output register and sets the mode to json.
// stalls:
//   when out_ch.ready is low the output byte holds; the queue fills and
//   in_ch.ready drops once it is full.
// ----------------------------------------------------------------------------
module byte_string_escaper
  import bse_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  bse_in_if.sink      in_ch,
  bse_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mode_t      mode;
  logic       q_full;
  logic       push;
  esc_entry_t push_entry;
  logic       pop;
  q_head_t    head;
  back_stat_t back_stat;

  // config port: single mode register, pready always high
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODE) ? {30'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_JSON;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MODE) begin
      mode <= mode_t'(pwdata[1:0]);
    end
  end

  // front: classify each accepted byte into a run descriptor
  bse_front u_front (
    .in_ch      (in_ch),
    .mode       (mode),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // descriptor queue decouples input acceptance from run expansion
  bse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head       (head)
  );

  // back: walk each descriptor one output byte at a time
  bse_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .stat   (back_stat),
    .out_ch (out_ch)
  );

  // the output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid after reset");

  // a run in progress keeps its descriptor at the queue head
  a_run_has_head: assert property (@(posedge clk) disable iff (rst)
    back_stat.mid_run |-> head.valid)
    else $error("run in progress without queued descriptor");

  // mid-run, the byte waiting at the output is never a run end
  a_run_not_last: assert property (@(posedge clk) disable iff (rst)
    back_stat.mid_run |-> !(out_ch.valid && out_ch.last))
    else $error("last flag shown in the middle of a run");

endmodule

@@ tb/byte_string_escaper_chk.sv @@
// ----------------------------------------------------------------------------
// byte_string_escaper_chk
// watches the byte channels and the register port of the escaper, predicts
// the escaped run for every raw byte and compares it byte by byte
// ----------------------------------------------------------------------------
module byte_string_escaper_chk
  import bse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bse_in_if           in_mon,
  bse_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        end_check,
  output int          errors,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } esc_out_t;

  localparam logic [0:15][7:0] HEX_LOWER = "0123456789abcdef";
  localparam logic [0:15][7:0] HEX_UPPER = "0123456789ABCDEF";

  esc_out_t escaped_q[$];
  mode_t    scheme;
  logic     end_reported;

  initial begin
    errors  = 0;
    checked = 0;
    pending = 0;
    end_reported = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // escaped run of one raw byte under the given scheme, returns its length
  function automatic int escape_byte(input mode_t m, input logic [BYTE_W-1:0] b,
                                     output logic [5:0][BYTE_W-1:0] run);
    logic [BYTE_W-1:0] name;
    int n;
    case (b)
      CH_LF:   name = CH_LC_N;
      CH_CR:   name = CH_LC_R;
      CH_TAB:  name = CH_LC_T;
      default: name = '0;
    endcase
    run    = '0;
    run[0] = CH_BSLASH;
    n      = 1;
    case (m)
      MODE_JSON: begin
        if (b == CH_QUOTE || b == CH_BSLASH) begin
          run[1] = b;
          n = 2;
        end else if (name != '0) begin
          run[1] = name;
          n = 2;
        end else if (b < CTRL_LIMIT) begin
          run[1] = CH_LC_U;
          run[2] = CH_ZERO;
          run[3] = CH_ZERO;
          run[4] = HEX_LOWER[b[7:4]];
          run[5] = HEX_LOWER[b[3:0]];
          n = 6;
        end
      end
      MODE_C: begin
        if (b == CH_BSLASH) begin
          run[1] = b;
          n = 2;
        end else if (name != '0) begin
          run[1] = name;
          n = 2;
        end else if (b < CTRL_LIMIT || b == CH_DEL) begin
          run[1] = CH_LC_X;
          run[2] = HEX_UPPER[b[7:4]];
          run[3] = HEX_UPPER[b[3:0]];
          n = 4;
        end
      end
      MODE_TSV: begin
        if (b == CH_BSLASH) begin
          run[1] = b;
          n = 2;
        end else if (name != '0) begin
          run[1] = name;
          n = 2;
        end
      end
      default: begin
        if (b == CH_BSLASH || b == CH_PIPE) begin
          run[1] = b;
          n = 2;
        end
      end
    endcase
    if (n == 1) run[0] = b;
    return n;
  endfunction

  always @(posedge clk) begin : monitor
    esc_out_t                 got;
    esc_out_t                 want;
    esc_out_t                 item;
    logic [5:0][BYTE_W-1:0]   run;
    int                       n;
    int                       i;
    if (rst) begin
      escaped_q.delete();
      scheme  <= MODE_JSON;
      pending <= 0;
    end else begin
      // output side first: a byte taken at this edge cannot show up yet
      if (out_mon.valid && out_mon.ready) begin
        got.value = out_mon.out_byte;
        got.last  = out_mon.last;
        checked++;
        if (escaped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", got.value, got.last));
        end else begin
          want = escaped_q.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("out_byte %02h, predicted %02h", got.value, want.value));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0b on byte %02h, predicted %0b",
                                      got.last, got.value, want.last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        n = escape_byte(scheme, in_mon.in_byte, run);
        for (i = 0; i < n; i++) begin
          item.value = run[i];
          item.last  = (i == n - 1);
          escaped_q = {escaped_q, item};
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_MODE)
        scheme <= mode_t'(pwdata[1:0]);
      if (end_check && !end_reported) begin
        end_reported = 1'b1;
        if (escaped_q.size() != 0)
          report_mismatch($sformatf("%0d predicted bytes never came out", escaped_q.size()));
      end
      pending <= escaped_q.size();
    end
  end

endmodule

@@ tb/byte_string_escaper_tb.sv @@
// ----------------------------------------------------------------------------
// byte_string_escaper_tb
// drives raw bytes into the escaper under all four schemes and lets the
// checker compare every escaped byte; random stalls on both channels, one
// long receiver hold-off and a mode change between drained bursts
// ----------------------------------------------------------------------------
module byte_string_escaper_tb;
  import bse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT       = 18;
  localparam int HOLD_CYCLES    = 64;   // long receiver hold-off
  localparam int BURST_LEN      = 13;   // random bytes per mode setting
  localparam int NUM_BURSTS     = 8;
  localparam int TAIL_CYCLES    = 8;    // quiet time after the last run
  localparam int WATCHDOG_LIMIT = 2000; // cycles without any transaction

  // directed bytes per scheme: extremes, every escaped class, pass-through
  localparam logic [0:10][7:0] JSON_DIRECTED = {8'h00, 8'h1F, CH_QUOTE, CH_BSLASH,
    CH_LF, CH_CR, CH_TAB, CTRL_LIMIT, CH_DEL, 8'hFF, 8'h80};
  localparam logic [0:5][7:0]  C_DIRECTED    = {8'h00, 8'h1B, CH_DEL, CH_BSLASH,
    CH_CR, CH_QUOTE};
  localparam logic [0:4][7:0]  TSV_DIRECTED  = {CH_BSLASH, CH_TAB, CH_LF, 8'h01,
    CH_PIPE};
  localparam logic [0:3][7:0]  MD_DIRECTED   = {CH_PIPE, CH_BSLASH, CH_QUOTE, CH_LF};

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        end_check;

  int    errors;
  int    pending;
  int    checked;
  int    rx_idle_pct;
  int    tx_idle_pct;
  logic  rx_hold;
  mode_t cur_mode;
  int    bytes_per_mode [4];
  int    quiet_cycles;

  bse_in_if  in_ch ();
  bse_out_if out_ch ();

  byte_string_escaper u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  byte_string_escaper_chk u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .end_check (end_check),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or fully held while rx_hold is up
  always @(posedge clk) begin
    out_ch.ready <= !rst && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog: a run that stops moving for too long is a failure
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one raw byte, with random gaps in front, and wait for the transaction
  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    bytes_per_mode[cur_mode]++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drop valid and wait until every predicted byte has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // two-phase register write to the mode register; only the low bits count
  task automatic write_mode(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MODE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = mode_t'(value[1:0]);
  endtask

  // receiver fully stalled for a counted stretch
  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // random byte weighted toward the classes that get escaped
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(3))
      0: b = 8'($urandom_range(31));
      1: begin
        case ($urandom_range(8))
          0: b = CH_QUOTE;
          1: b = CH_BSLASH;
          2: b = CH_PIPE;
          3: b = CH_LF;
          4: b = CH_CR;
          5: b = CH_TAB;
          6: b = CH_DEL;
          7: b = CTRL_LIMIT;
          default: b = 8'($urandom_range(255, 128));
        endcase
      end
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_byte(pick_byte());
  endtask

  initial begin : stimulus
    int          k;
    int          burst;
    logic [31:0] value;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    end_check     = 1'b0;
    rx_hold       = 1'b0;
    rx_idle_pct   = IDLE_PCT;
    tx_idle_pct   = IDLE_PCT;
    quiet_cycles  = 0;
    cur_mode      = MODE_JSON;
    bytes_per_mode = '{default: 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // json straight out of reset, no register write yet
    for (k = 0; k < 11; k++) send_byte(JSON_DIRECTED[k]);
    wait_drained();
    // c mode written with every upper bit set
    write_mode(32'hFFFF_FFFD);
    for (k = 0; k < 6; k++) send_byte(C_DIRECTED[k]);
    wait_drained();
    write_mode(32'h0000_0002);
    for (k = 0; k < 5; k++) send_byte(TSV_DIRECTED[k]);
    wait_drained();
    write_mode(32'hA5A5_A5A7);
    for (k = 0; k < 4; k++) send_byte(MD_DIRECTED[k]);

    // random bursts, each under its own mode setting after a full drain
    for (burst = 0; burst < NUM_BURSTS; burst++) begin
      wait_drained();
      value = ($urandom() & 32'hFFFF_FFFC) |
              ((burst < 4) ? 32'(burst) : 32'($urandom_range(3)));
      write_mode(value);
      if (burst == 2) begin
        // the receiver stalls long enough that the input side backs up;
        // the burst cannot finish before the hold-off ends
        fork
          hold_receiver(HOLD_CYCLES);
          send_random(BURST_LEN);
        join
      end else if (burst == 5) begin
        // one stretch at full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        send_random(BURST_LEN);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct <= IDLE_PCT;
      end else begin
        send_random(BURST_LEN);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("sent %0d raw bytes: json %0d, c %0d, tsv %0d, markdown %0d",
             bytes_per_mode[MODE_JSON] + bytes_per_mode[MODE_C] +
             bytes_per_mode[MODE_TSV] + bytes_per_mode[MODE_MD],
             bytes_per_mode[MODE_JSON], bytes_per_mode[MODE_C],
             bytes_per_mode[MODE_TSV], bytes_per_mode[MODE_MD]);
    $display("compared %0d escaped bytes, with a %0d-cycle receiver hold-off",
             checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
